// ----- hdl/fec_block_repair_mask_tracker_core_assert.svh -----
// Assertion macros shared by the checker files of this block.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef FEC_BLOCK_REPAIR_MASK_TRACKER_CORE_ASSERT_SVH
`define FEC_BLOCK_REPAIR_MASK_TRACKER_CORE_ASSERT_SVH

// Assertion that is switched off while reset is high.
`define FBRMT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion that is checked during reset as well.
`define FBRMT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/fbrmt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FEC block repair mask tracker package
// Widths, operation codes, register indexes and the request plan structure.
// ----------------------------------------------------------------------------
package fbrmt_pkg;

   localparam int BLOCK_SEGMENTS_DEF = 256;

   localparam int ID_W     = 8;
   localparam int COUNT_W  = 9;
   localparam int DS_W     = 9;
   localparam int PS_W     = 8;
   localparam int OP_W     = 2;
   localparam int CMP_W    = 11;   // holds every id up to the largest block and every run end
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 9;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 8;

   typedef enum logic [OP_W-1:0] {
      OP_REQUEST  = 2'd0,
      OP_HOLDOFF  = 2'd1,
      OP_ACTIVATE = 2'd2,
      OP_CLEAR    = 2'd3
   } fbrmt_op_type;

   localparam logic [CSR_IDX_W-1:0] CSR_DATA_SEGMENTS   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_PARITY_SEGMENTS = 1'b1;

   // What one request or holdoff does to its target mask and the parity counters.
   typedef struct packed {
      logic               run_en;
      logic [CMP_W-1:0]   run_lo;
      logic [CMP_W-1:0]   run_hi;
      logic [CMP_W-1:0]   rng_lo;
      logic [CMP_W-1:0]   rng_hi;
      logic               grew;
      logic [COUNT_W-1:0] off_next;
      logic [COUNT_W-1:0] req_next;
   } fbrmt_plan_type;

endpackage

// ----- hdl/fbrmt_req_plan.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FEC block repair mask tracker request planner
// Chooses between an explicit id range and fresh parity with fallback.
// ----------------------------------------------------------------------------
module fbrmt_req_plan (
   input  logic [fbrmt_pkg::ID_W-1:0]    first_id,
   input  logic [fbrmt_pkg::ID_W-1:0]    last_id,
   input  logic [fbrmt_pkg::COUNT_W-1:0] erasures,
   input  logic [fbrmt_pkg::DS_W-1:0]    data_segments,
   input  logic [fbrmt_pkg::PS_W-1:0]    parity_segments,
   input  logic [fbrmt_pkg::COUNT_W-1:0] parity_used,
   input  logic [fbrmt_pkg::COUNT_W-1:0] parity_requested,
   output fbrmt_pkg::fbrmt_plan_type     plan
);

   import fbrmt_pkg::*;

   logic               explicit_req;
   logic [COUNT_W-1:0] ps_ext;
   logic [COUNT_W-1:0] avail;
   logic [CMP_W-1:0]   base;

   always_comb begin
      explicit_req = {1'b0, first_id} < data_segments;
      ps_ext       = {1'b0, parity_segments};
      avail        = (parity_used > ps_ext) ? '0 : ps_ext - parity_used;
      base         = CMP_W'(data_segments) + CMP_W'(parity_used) + CMP_W'(parity_requested);

      plan          = '0;
      plan.off_next = parity_used;
      plan.req_next = parity_requested;
      plan.rng_lo   = CMP_W'(first_id);
      plan.rng_hi   = CMP_W'(last_id);

      if (explicit_req) begin
         plan.off_next = ps_ext;
         plan.req_next = ps_ext;
      end else if (erasures <= avail) begin
         // Enough parity: no explicit range, just top up the parity run.
         plan.rng_lo = CMP_W'(1);
         plan.rng_hi = '0;
         if (erasures > parity_requested) begin
            plan.run_en   = 1'b1;
            plan.run_lo   = base;
            plan.run_hi   = CMP_W'(data_segments) + CMP_W'(parity_used)
                            + CMP_W'(erasures) - CMP_W'(1);
            plan.req_next = erasures;
            plan.grew     = 1'b1;
         end
      end else begin
         // Too little parity: take what is left, then fall back to explicit ids.
         if (parity_requested < avail) begin
            plan.run_en   = 1'b1;
            plan.run_lo   = base;
            plan.run_hi   = CMP_W'(data_segments) + CMP_W'(parity_used)
                            + CMP_W'(avail) - CMP_W'(1);
            plan.req_next = avail;
            plan.rng_lo   = CMP_W'(first_id) + CMP_W'(avail);
            plan.grew     = 1'b1;
         end
      end
   end

endmodule

// ----- hdl/fec_block_repair_mask_tracker_core.sv -----
`timescale 1ns / 1ps
// A request word is taken into the input word register and moves on to the result register
// when the output is free. Throughput: one word per cycle unless a result waits at the output;
// the repair and pending masks are updated in one pass by the mask update logic between the
// word register and the result register, which also carries the state forward for the next word.
// Reset (synchronous, active high) clears both masks, the parity counters, the in-repair
// flag and both handshake stages, and returns the registers to one data segment, no parity.
// ----------------------------------------------------------------------------
// FEC block repair mask tracker core
// Sender-side repair and pending masks for one FEC block of data and parity segments.
// ----------------------------------------------------------------------------
module fec_block_repair_mask_tracker_core #(
   parameter int BLOCK_SEGMENTS = fbrmt_pkg::BLOCK_SEGMENTS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata, lowest bit up: first_id[7:0], last_id[15:8], erasures[24:16], zero fill.
   input  logic [fbrmt_pkg::REQ_DATA_W-1:0]    req_tdata,
   // tuser, lowest bit up: operation[1:0].
   input  logic [fbrmt_pkg::OP_W-1:0]          req_tuser,
   // Result channel.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // tdata, lowest bit up: changed[0], repair_any[1], pending_any[2], repair_flag[3],
   // zero fill.
   output logic [fbrmt_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // Configuration write channel.
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [fbrmt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [fbrmt_pkg::CSR_DATA_W-1:0]    csr_data
);

   import fbrmt_pkg::*;

   // Configuration registers. Writes are always taken.
   logic [DS_W-1:0] ds_ff;
   logic [PS_W-1:0] ps_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ds_ff <= DS_W'(1);
         ps_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_DATA_SEGMENTS:   ds_ff <= csr_data[DS_W-1:0];
            CSR_PARITY_SEGMENTS: ps_ff <= csr_data[PS_W-1:0];
            default:             ;
         endcase
      end
   end

   // Input word register. It refills in the same cycle that its word moves on to the
   // result register. While a result waits at the output it holds one word and the
   // request channel stalls.
   logic               in_valid_ff;
   fbrmt_op_type       op_ff;
   logic [ID_W-1:0]    first_ff;
   logic [ID_W-1:0]    last_ff;
   logic [COUNT_W-1:0] eras_ff;
   logic               fire;

   assign fire       = in_valid_ff && (!rsp_tvalid || rsp_tready);
   assign req_tready = !in_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         op_ff    <= fbrmt_op_type'(req_tuser);
         first_ff <= req_tdata[ID_W-1:0];
         last_ff  <= req_tdata[2*ID_W-1:ID_W];
         eras_ff  <= req_tdata[2*ID_W+COUNT_W-1:2*ID_W];
      end
   end

   // Tracker state.
   logic [BLOCK_SEGMENTS-1:0] repair_ff, repair_in;
   logic [BLOCK_SEGMENTS-1:0] pending_ff, pending_in;
   logic [COUNT_W-1:0]        off_ff, off_in;
   logic [COUNT_W-1:0]        preq_ff, preq_in;
   logic                      active_ff, active_in;

   // The planner decides where the parity run and the explicit range fall.
   fbrmt_plan_type plan;

   fbrmt_req_plan u_plan (
      .first_id         (first_ff),
      .last_id          (last_ff),
      .erasures         (eras_ff),
      .data_segments    (ds_ff),
      .parity_segments  (ps_ff),
      .parity_used      (off_ff),
      .parity_requested (preq_ff),
      .plan             (plan)
   );

   // Bits that the current request would set, two compare pairs per id (parity run and explicit
   // range). Ids past the block simply have no bit, which is how out-of-block ids are dropped.
   logic [BLOCK_SEGMENTS-1:0] hit;
   logic [BLOCK_SEGMENTS-1:0] target;
   logic                      changed;

   always_comb begin
      for (int i = 0; i < BLOCK_SEGMENTS; i++) begin
         hit[i] = (plan.run_en && (CMP_W'(i) >= plan.run_lo) && (CMP_W'(i) <= plan.run_hi))
                  || ((CMP_W'(i) >= plan.rng_lo) && (CMP_W'(i) <= plan.rng_hi));
      end
   end

   always_comb begin
      repair_in  = repair_ff;
      pending_in = pending_ff;
      off_in     = off_ff;
      preq_in    = preq_ff;
      active_in  = active_ff;
      changed    = 1'b0;
      target     = (op_ff == OP_HOLDOFF) ? pending_ff : repair_ff;

      case (op_ff)
         OP_REQUEST, OP_HOLDOFF: begin
            // A parity request that found parity reports a change even when the run
            // lies past the block; an explicit range counts only newly set ids.
            changed = plan.grew || (|(hit & ~target));
            off_in  = plan.off_next;
            preq_in = plan.req_next;
            if (op_ff == OP_REQUEST) begin
               repair_in = repair_ff | hit;
            end else begin
               pending_in = pending_ff | hit;
            end
         end
         OP_ACTIVATE: begin
            if (|repair_ff) begin
               pending_in = pending_ff | repair_ff;
               repair_in  = '0;
               active_in  = 1'b1;
               changed    = 1'b1;
            end
         end
         OP_CLEAR: begin
            repair_in  = '0;
            pending_in = '0;
            off_in     = '0;
            preq_in    = '0;
            active_in  = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         repair_ff  <= '0;
         pending_ff <= '0;
         off_ff     <= '0;
         preq_ff    <= '0;
         active_ff  <= 1'b0;
      end else if (fire) begin
         repair_ff  <= repair_in;
         pending_ff <= pending_in;
         off_ff     <= off_in;
         preq_ff    <= preq_in;
         active_ff  <= active_in;
      end
   end

   // Result register. The summary flags are taken from the state after the step.
   logic rsp_valid_ff;
   logic changed_ff, repair_any_ff, pending_any_ff, active_out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         changed_ff     <= changed;
         repair_any_ff  <= |repair_in;
         pending_any_ff <= |pending_in;
         active_out_ff  <= active_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-4){1'b0}},
                        active_out_ff, pending_any_ff, repair_any_ff, changed_ff};

endmodule

// ----- hdl/fbrmt_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FEC block repair mask tracker port checker
// Watches the result channel of the core over time.
// ----------------------------------------------------------------------------
`include "fec_block_repair_mask_tracker_core_assert.svh"

module fbrmt_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [fbrmt_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   import fbrmt_pkg::*;

   // A stalled result must hold.
   `FBRMT_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "result changed while stalled")

   // Reset empties the result stage.
   `FBRMT_ASSERT_ALWAYS(a_rsp_reset, clock, reset |=> !rsp_tvalid, "result valid after reset")

   // The fill bits above the four flags stay zero.
   `FBRMT_ASSERT(a_rsp_fill, clock, reset, rsp_tvalid |-> rsp_tdata[RSP_DATA_W-1:4] == '0, "nonzero fill bits in result")

endmodule

bind fec_block_repair_mask_tracker_core fbrmt_checker u_fbrmt_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- verif/fec_block_repair_mask_tracker_core_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FEC block repair mask tracker checker
// Follows the request, result and register channels, keeps its own copy of
// the repair state and compares every result word with its prediction.
// ----------------------------------------------------------------------------
module fec_block_repair_mask_tracker_core_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [fbrmt_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [fbrmt_pkg::OP_W-1:0]       req_tuser,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [fbrmt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [fbrmt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fbrmt_pkg::CSR_DATA_W-1:0] csr_data,
   output int                               mismatch_count,
   output int                               results_outstanding
);

   import fbrmt_pkg::*;

   localparam int SEGMENTS = BLOCK_SEGMENTS_DEF;

   // Packed so that changed lands in bit 0, as on the result port.
   typedef struct packed {
      logic repair_flag;
      logic pending_any;
      logic repair_any;
      logic changed;
   } tracker_status_type;

   logic [DS_W-1:0]     cfg_data_segments;
   logic [PS_W-1:0]     cfg_parity_segments;
   logic [SEGMENTS-1:0] repair_bits;
   logic [SEGMENTS-1:0] pending_bits;
   logic [COUNT_W-1:0]  parity_used;
   logic [COUNT_W-1:0]  parity_taken;
   logic                repair_active;
   tracker_status_type  expected_status_q[$];
   int                  mismatches = 0;
   int                  queued_results = 0;

   assign mismatch_count      = mismatches;
   assign results_outstanding = queued_results;

   task automatic report_mismatch(input string what, input logic [8:0] want,
                                  input logic [8:0] got);
      mismatches++;
      $display("%0t: mismatch in %s, expected %0h, got %0h", $time, what, want, got);
   endtask

   function automatic logic [SEGMENTS-1:0] with_range(input logic [SEGMENTS-1:0] mask,
                                                      input int unsigned lo,
                                                      input int unsigned hi);
      for (int unsigned id = lo; id <= hi; id++)
         if (id < SEGMENTS) mask[id] = 1'b1;
      return mask;
   endfunction

   function automatic logic [SEGMENTS-1:0] with_run(input logic [SEGMENTS-1:0] mask,
                                                    input int unsigned start,
                                                    input int unsigned count);
      for (int unsigned i = 0; i < count && start + i < SEGMENTS; i++)
         mask[start + i] = 1'b1;
      return mask;
   endfunction

   function automatic void clear_tracker();
      repair_bits   = '0;
      pending_bits  = '0;
      parity_used   = '0;
      parity_taken  = '0;
      repair_active = 1'b0;
   endfunction

   // Request and holdoff share one rule and differ only in the target mask.
   function automatic bit absorb_request(input bit into_pending, input logic [ID_W-1:0] lo_id,
                                         input logic [ID_W-1:0] hi_id,
                                         input logic [COUNT_W-1:0] erasure_total);
      logic [SEGMENTS-1:0] mask;
      logic [SEGMENTS-1:0] prior;
      int unsigned first, last, erasures, ds, ps, offset, taken, avail;
      bit grew;
      mask     = into_pending ? pending_bits : repair_bits;
      first    = lo_id;
      last     = hi_id;
      erasures = erasure_total;
      ds       = cfg_data_segments;
      ps       = cfg_parity_segments;
      offset   = parity_used;
      taken    = parity_taken;
      grew     = 1'b0;
      if (first < ds) begin
         parity_used  = COUNT_W'(ps);
         parity_taken = COUNT_W'(ps);
         prior = mask;
         mask  = with_range(mask, first, last);
         grew  = (mask != prior);
      end else begin
         // The offset can exceed the parity count after a register change.
         avail = (offset > ps) ? 0 : ps - offset;
         if (erasures <= avail) begin
            if (erasures > taken) begin
               mask = with_run(mask, ds + offset + taken, erasures - taken);
               parity_taken = COUNT_W'(erasures);
               grew = 1'b1;
            end
         end else begin
            // Not enough parity: take what is left, then fall back to explicit ids.
            if (taken < avail) begin
               mask = with_run(mask, ds + offset + taken, avail - taken);
               parity_taken = COUNT_W'(avail);
               first += avail;
               grew = 1'b1;
            end
            prior = mask;
            mask  = with_range(mask, first, last);
            if (mask != prior) grew = 1'b1;
         end
      end
      if (into_pending) pending_bits = mask;
      else repair_bits = mask;
      return grew;
   endfunction

   function automatic tracker_status_type predict_status(input logic [REQ_DATA_W-1:0] data,
                                                         input logic [OP_W-1:0] user);
      tracker_status_type status;
      status = '0;
      case (fbrmt_op_type'(user))
         OP_REQUEST: begin
            status.changed = absorb_request(1'b0, data[7:0], data[15:8], data[24:16]);
         end
         OP_HOLDOFF: begin
            status.changed = absorb_request(1'b1, data[7:0], data[15:8], data[24:16]);
         end
         OP_ACTIVATE: begin
            if (|repair_bits) begin
               pending_bits   = pending_bits | repair_bits;
               repair_bits    = '0;
               repair_active  = 1'b1;
               status.changed = 1'b1;
            end
         end
         OP_CLEAR: begin
            clear_tracker();
         end
         default: ;
      endcase
      status.repair_any  = |repair_bits;
      status.pending_any = |pending_bits;
      status.repair_flag = repair_active;
      return status;
   endfunction

   task automatic check_status(input logic [RSP_DATA_W-1:0] word);
      tracker_status_type got, want;
      got = tracker_status_type'(word[3:0]);
      if (expected_status_q.size() == 0) begin
         report_mismatch("result word with no request outstanding", 9'd0, 9'(word));
      end else begin
         want = expected_status_q.pop_front();
         if (got.changed !== want.changed)
            report_mismatch("changed", 9'(want.changed), 9'(got.changed));
         if (got.repair_any !== want.repair_any)
            report_mismatch("repair_any", 9'(want.repair_any), 9'(got.repair_any));
         if (got.pending_any !== want.pending_any)
            report_mismatch("pending_any", 9'(want.pending_any), 9'(got.pending_any));
         if (got.repair_flag !== want.repair_flag)
            report_mismatch("repair_flag", 9'(want.repair_flag), 9'(got.repair_flag));
         if (word[RSP_DATA_W-1:4] !== '0)
            report_mismatch("zero fill", 9'd0, 9'(word[RSP_DATA_W-1:4]));
      end
   endtask

   // Results are checked before the new request is predicted: the block's
   // latency keeps a word accepted at this edge from answering at the same edge.
   always @(posedge clock) begin
      if (reset) begin
         clear_tracker();
         cfg_data_segments   = DS_W'(1);
         cfg_parity_segments = '0;
         expected_status_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) check_status(rsp_tdata);
         if (req_tvalid && req_tready)
            expected_status_q.push_back(predict_status(req_tdata, req_tuser));
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DATA_SEGMENTS:   cfg_data_segments   = csr_data[DS_W-1:0];
               CSR_PARITY_SEGMENTS: cfg_parity_segments = csr_data[PS_W-1:0];
               default: ;
            endcase
         end
      end
      queued_results <= expected_status_q.size();
   end

endmodule

// ----- verif/fec_block_repair_mask_tracker_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FEC block repair mask tracker testbench
// Drives request words and register writes into the tracker with random
// gaps and back pressure; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module fec_block_repair_mask_tracker_core_tb;
   import fbrmt_pkg::*;

   // Request words to send in total, directed ones included.
   localparam int WORDS_TOTAL  = 1100;
   // Margin added once every predicted result word has come back.
   localparam int DRAIN_CYCLES = 6;
   // Cycles without any accepted word before the run is declared hung.
   localparam int STALL_LIMIT  = 2000;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [OP_W-1:0]       req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   int          mismatch_count;
   int          results_outstanding;
   int          words_sent;
   // When set, neither side inserts gaps, so the block runs at full rate.
   bit          idle_free;
   // Register values last written, used to aim the random ids at each region.
   int unsigned cur_data_segments;
   int unsigned cur_parity_segments;

   fec_block_repair_mask_tracker_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   fec_block_repair_mask_tracker_core_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_tvalid          (req_tvalid),
      .req_tready          (req_tready),
      .req_tdata           (req_tdata),
      .req_tuser           (req_tuser),
      .rsp_tvalid          (rsp_tvalid),
      .rsp_tready          (rsp_tready),
      .rsp_tdata           (rsp_tdata),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .mismatch_count      (mismatch_count),
      .results_outstanding (results_outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: any handshake on any channel restarts the count. A block that
   // stops answering, or a result that never arrives, ends the run here.
   initial begin : watchdog
      int stalled;
      stalled = 0;
      while (stalled < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            stalled = 0;
         else
            stalled++;
      end
      $display("FAIL fec_block_repair_mask_tracker_core");
      $finish;
   end

   // Result side: before each result word, hold tready low for a random number
   // of cycles, then keep it high until a word is taken.
   initial begin : result_sink
      int gap;
      rsp_tready = 1'b0;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         gap = idle_free ? 0 : $urandom_range(0, 8);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Sends one request word after a random gap. tvalid is left high on return
   // so that a following word with no gap goes out back to back.
   task automatic send_word(input fbrmt_op_type op, input logic [ID_W-1:0] first_id,
                            input logic [ID_W-1:0] last_id,
                            input logic [COUNT_W-1:0] erasures);
      int gap;
      gap = idle_free ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {7'd0, erasures, last_id, first_id};
      do @(posedge clock); while (!req_tready);
      words_sent++;
   endtask

   // Stops the request stream and waits until every predicted result word has
   // come back, then lets the pipeline settle. The first edge lets the
   // checker's count take in a word accepted at the current edge.
   task automatic wait_until_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results_outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_one(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Writes both registers, in random order. Only called while the block is idle.
   task automatic write_registers(input logic [CSR_DATA_W-1:0] data_segs,
                                  input logic [CSR_DATA_W-1:0] parity_segs);
      if ($urandom_range(0, 1) == 1) begin
         write_one(CSR_DATA_SEGMENTS, data_segs);
         write_one(CSR_PARITY_SEGMENTS, parity_segs);
      end else begin
         write_one(CSR_PARITY_SEGMENTS, parity_segs);
         write_one(CSR_DATA_SEGMENTS, data_segs);
      end
      csr_valid <= 1'b0;
      cur_data_segments   = data_segs;
      cur_parity_segments = parity_segs[PS_W-1:0];
   endtask

   // Picks a block layout: the extremes often, an out-of-range data count or a free parity
   // count now and then, and otherwise a layout whose data plus parity fits the block.
   task automatic pick_registers();
      int unsigned ds, ps;
      case ($urandom_range(0, 9))
         0:       ds = 0;
         1:       ds = 1;
         2:       ds = 256;
         3:       ds = 511;
         4, 5, 6: ds = $urandom_range(1, 32);
         default: ds = $urandom_range(1, 256);
      endcase
      case ($urandom_range(0, 5))
         0:       ps = 0;
         1:       ps = 255;
         2:       ps = $urandom_range(0, 255);
         default: ps = (ds < 256) ? $urandom_range(0, (ds == 0) ? 255 : 256 - ds) : 0;
      endcase
      write_registers(CSR_DATA_W'(ds), CSR_DATA_W'(ps));
   endtask

   // Random traffic. Ids are aimed at the data region, the parity region, or
   // anywhere, and erasure counts mostly sit around the parity count so that
   // both the fresh-parity and the fallback paths are taken.
   task automatic run_random_phase(input int count);
      int          pick;
      int unsigned first, last, erasures;
      fbrmt_op_type op;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 45)      op = OP_REQUEST;
         else if (pick < 75) op = OP_HOLDOFF;
         else if (pick < 94) op = OP_ACTIVATE;
         else                op = OP_CLEAR;
         case ($urandom_range(0, 2))
            0: begin
               if (cur_data_segments == 0) first = $urandom_range(0, 255);
               else if (cur_data_segments > 256) first = $urandom_range(0, 255);
               else first = $urandom_range(0, cur_data_segments - 1);
            end
            1: begin
               if (cur_data_segments <= 255) first = $urandom_range(cur_data_segments, 255);
               else first = $urandom_range(0, 255);
            end
            default: first = $urandom_range(0, 255);
         endcase
         if ($urandom_range(0, 3) == 0) begin
            last = $urandom_range(0, 255);
         end else begin
            last = first + $urandom_range(0, 12);
            if (last > 255) last = 255;
         end
         if ($urandom_range(0, 9) < 7)
            erasures = $urandom_range(0, (cur_parity_segments + 3 > 256) ?
                                         256 : cur_parity_segments + 3);
         else
            erasures = $urandom_range(0, 256);
         send_word(op, ID_W'(first), ID_W'(last), COUNT_W'(erasures));
         // Occasionally hold the sender back until everything has come out.
         if ($urandom_range(0, 149) == 0) wait_until_drained();
      end
   endtask

   initial begin
      reset               = 1'b1;
      req_tvalid          = 1'b0;
      req_tdata           = '0;
      req_tuser           = OP_REQUEST;
      csr_valid           = 1'b0;
      csr_index           = CSR_DATA_SEGMENTS;
      csr_data            = '0;
      idle_free           = 1'b0;
      words_sent          = 0;
      cur_data_segments   = 1;
      cur_parity_segments = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset layout, one data segment and no parity.
      // Activate with nothing to move reports no change.
      send_word(OP_ACTIVATE, 8'd0, 8'd0, 9'd0);
      send_word(OP_REQUEST, 8'd0, 8'd0, 9'd0);
      // The same id again sets nothing new.
      send_word(OP_REQUEST, 8'd0, 8'd0, 9'd0);
      // Parity path with no parity and an empty range.
      send_word(OP_REQUEST, 8'd5, 8'd2, 9'd256);
      send_word(OP_HOLDOFF, 8'd0, 8'd255, 9'd0);
      send_word(OP_ACTIVATE, 8'd0, 8'd0, 9'd0);
      send_word(OP_CLEAR, 8'd255, 8'd255, 9'd511);

      // Four data and eight parity segments: draw parity in steps, then run
      // out of it and fall back to explicit ids.
      wait_until_drained();
      write_registers(9'd4, 9'd8);
      send_word(OP_REQUEST, 8'd10, 8'd20, 9'd3);
      send_word(OP_REQUEST, 8'd10, 8'd20, 9'd5);
      send_word(OP_REQUEST, 8'd10, 8'd20, 9'd12);
      send_word(OP_HOLDOFF, 8'd255, 8'd255, 9'd256);
      send_word(OP_REQUEST, 8'd2, 8'd3, 9'd0);
      send_word(OP_REQUEST, 8'd200, 8'd255, 9'd1);

      // Shrink the parity count under the used offset: available parity is zero.
      wait_until_drained();
      write_registers(9'd4, 9'd2);
      send_word(OP_REQUEST, 8'd100, 8'd110, 9'd0);
      send_word(OP_REQUEST, 8'd100, 8'd110, 9'd3);
      send_word(OP_ACTIVATE, 8'd0, 8'd0, 9'd0);
      send_word(OP_CLEAR, 8'd0, 8'd0, 9'd0);

      // No data segments: every request takes the parity path; the parity run ends just
      // below the top of the block, and the fallback range sets the top id.
      wait_until_drained();
      write_registers(9'd0, 9'd255);
      send_word(OP_REQUEST, 8'd0, 8'd255, 9'd256);
      send_word(OP_HOLDOFF, 8'd0, 8'd255, 9'd255);
      send_word(OP_CLEAR, 8'd0, 8'd0, 9'd0);

      // Largest data count: every id is a data id.
      wait_until_drained();
      write_registers(9'd256, 9'd0);
      send_word(OP_REQUEST, 8'd255, 8'd255, 9'd0);
      send_word(OP_HOLDOFF, 8'd0, 8'd255, 9'd256);
      send_word(OP_ACTIVATE, 8'd0, 8'd0, 9'd0);

      // Random phases. A phase sometimes starts without a clear, so that
      // leftover offsets meet a new layout.
      while (words_sent < WORDS_TOTAL) begin
         if ($urandom_range(0, 2) == 0)
            send_word(OP_CLEAR, ID_W'($urandom()), ID_W'($urandom()), COUNT_W'($urandom()));
         wait_until_drained();
         pick_registers();
         idle_free = ($urandom_range(0, 3) == 0);
         run_random_phase($urandom_range(20, 120));
      end

      idle_free = 1'b0;
      wait_until_drained();
      if (mismatch_count == 0)
         $display("PASS fec_block_repair_mask_tracker_core");
      else
         $display("FAIL fec_block_repair_mask_tracker_core");
      $finish;
   end

endmodule
